[sv/power_trend_life_monitor_core_defines.svh]
// Assertion macros used by the power trend monitor RTL (ptlm_ctrl).
// Depends on nothing; files that assert include it by name.
`ifndef POWER_TREND_LIFE_MONITOR_CORE_DEFINES_SVH
`define POWER_TREND_LIFE_MONITOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTLM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ptlm assertion failed");
`define PTLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptlm assertion failed");
`else
`define PTLM_ASSERT(lbl, cond)
`define PTLM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/ptlm_pkg.sv]
// Shared widths, command codes and control structs of the power trend monitor.
// No dependencies.
package ptlm_pkg;
  localparam int SHOT_W  = 24;
  localparam int POW_W   = 16;
  localparam int CNT_W   = 13;
  localparam int SS_W    = 36;
  localparam int SP_W    = 28;
  localparam int SQ_W    = 60;
  localparam int SSP_W   = 52;
  localparam int DEN_W   = 73;
  localparam int NUM_W   = 64;
  localparam int MP_W    = 89;
  localparam int MB_W    = 36;
  localparam int REM_W   = DEN_W + 1;
  localparam int FRAC_W  = 16;
  localparam int SLOPE_W = 32;
  localparam int RUL_W   = 30;
  localparam int MCNT_W  = 6;
  localparam int DCNT_W  = 7;
  localparam int SEL_W   = 3;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(4096);
  localparam logic [RUL_W-1:0] RUL_UNLIMITED = RUL_W'(1000000000);

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_LOAD      = 3'd1;
  localparam logic [2:0] OP_MUL_START = 3'd2;
  localparam logic [2:0] OP_MUL_SAVE  = 3'd3;
  localparam logic [2:0] OP_DIV_START = 3'd4;
  localparam logic [2:0] OP_DIV_SAVE  = 3'd5;
  localparam logic [2:0] OP_PUBLISH   = 3'd6;

  // product steps
  localparam logic [SEL_W-1:0] SEL_N_SQ   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_SS_SS  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_N_SP   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_SS_SPW = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DIFF   = 3'd4;
  // division steps
  localparam logic [SEL_W-1:0] SEL_SLOPE  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_RUL    = 3'd1;

  typedef struct packed {
    logic [2:0]       op;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;
endpackage

[sv/ptlm_ctrl.sv]
// Sequencer of the power trend monitor: issues load, multiply, divide and
// publish commands to the datapath. Depends on ptlm_pkg and the defines header.
`include "power_trend_life_monitor_core_defines.svh"
module ptlm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptlm_pkg::status_t sts,
  output ptlm_pkg::cmd_t    cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_MWAIT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [ptlm_pkg::SEL_W-1:0] step_r, step_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.op    = ptlm_pkg::OP_NONE;
    cmd.sel   = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = ptlm_pkg::OP_LOAD;
          step_nxt  = ptlm_pkg::SEL_N_SQ;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op    = ptlm_pkg::OP_MUL_START;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (!sts.busy) begin
          cmd.op = ptlm_pkg::OP_MUL_SAVE;
          if (step_r == ptlm_pkg::SEL_DIFF) begin
            step_nxt  = ptlm_pkg::SEL_SLOPE;
            state_nxt = ST_DIV;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd.op    = ptlm_pkg::OP_DIV_START;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!sts.busy) begin
          cmd.op = ptlm_pkg::OP_DIV_SAVE;
          if (step_r == ptlm_pkg::SEL_RUL) begin
            state_nxt = ST_OUT;
          end else begin
            step_nxt  = ptlm_pkg::SEL_RUL;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.op    = ptlm_pkg::OP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `PTLM_ASSERT(a_publish_free, (cmd.op != ptlm_pkg::OP_PUBLISH) || sts.out_free)
  `PTLM_ASSERT(a_start_idle_unit,
      !(cmd.op == ptlm_pkg::OP_MUL_START || cmd.op == ptlm_pkg::OP_DIV_START) || !sts.busy)
  `PTLM_ASSERT_NEXT(a_load_then_mul, in_valid && in_ready, state_r == ST_MUL)
endmodule

[sv/ptlm_dp.sv]
// Datapath of the power trend monitor: running sums, a bit-serial multiplier,
// a restoring divider and the result register. Depends on ptlm_pkg.
module ptlm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptlm_pkg::cmd_t                cmd,
  output ptlm_pkg::status_t             sts,
  input  logic                          cfg_valid,
  input  logic [15:0]                   cfg_data,
  input  logic [ptlm_pkg::SHOT_W-1:0]   in_shot_index,
  input  logic [ptlm_pkg::POW_W-1:0]    in_power_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptlm_pkg::CNT_W-1:0]    out_sample_total,
  output logic [ptlm_pkg::POW_W-1:0]    out_latest_power,
  output logic signed [ptlm_pkg::SLOPE_W-1:0] out_trend_slope,
  output logic                          out_service_due,
  output logic [ptlm_pkg::RUL_W-1:0]    out_shots_remaining,
  output logic                          out_sample_rejected
);
  localparam int MP_W  = ptlm_pkg::MP_W;
  localparam int DEN_W = ptlm_pkg::DEN_W;
  localparam int NUM_W = ptlm_pkg::NUM_W;
  localparam int REM_W = ptlm_pkg::REM_W;
  localparam int MB_W  = ptlm_pkg::MB_W;

  logic [15:0]                  floor_r;
  logic [ptlm_pkg::CNT_W-1:0]   count_r;
  logic [ptlm_pkg::SS_W-1:0]    ss_r;
  logic [ptlm_pkg::SP_W-1:0]    sp_r;
  logic [ptlm_pkg::SQ_W-1:0]    sq_r;
  logic [ptlm_pkg::SSP_W-1:0]   ssp_r;
  logic [ptlm_pkg::POW_W-1:0]   last_r;
  logic                         rej_r;

  logic [DEN_W-1:0]             t_r, den_r;
  logic [NUM_W-1:0]             num_mag_r;
  logic                         num_neg_r;
  logic [MP_W-1:0]              prod_r;

  logic [DEN_W-1:0]             mul_a_r;
  logic [MB_W-1:0]              mul_b_r;
  logic [MP_W-1:0]              mul_p_r;
  logic [ptlm_pkg::MCNT_W-1:0]  mul_cnt_r;

  logic [MP_W-1:0]              div_q_r;
  logic [REM_W-1:0]             div_rem_r;
  logic [DEN_W-1:0]             div_d_r;
  logic [ptlm_pkg::DCNT_W-1:0]  div_cnt_r;

  logic [ptlm_pkg::SLOPE_W-1:0] slope_r;
  logic                         svc_r;
  logic [ptlm_pkg::RUL_W-1:0]   rul_r;

  logic                         ov_r;
  logic [ptlm_pkg::CNT_W-1:0]   o_cnt_r;
  logic [ptlm_pkg::POW_W-1:0]   o_last_r;
  logic [ptlm_pkg::SLOPE_W-1:0] o_slope_r;
  logic                         o_svc_r;
  logic [ptlm_pkg::RUL_W-1:0]   o_rul_r;
  logic                         o_rej_r;

  logic [DEN_W-1:0]             op_a;
  logic [MB_W-1:0]              op_b;
  logic [ptlm_pkg::POW_W-1:0]   diff;
  logic [REM_W-1:0]             rem_sh;
  logic                         rem_ge;
  logic                         den_zero, q_sat, service;
  logic [2*ptlm_pkg::SHOT_W-1:0]             shot_sq;
  logic [ptlm_pkg::SHOT_W+ptlm_pkg::POW_W-1:0] shot_pw;

  assign diff     = last_r - floor_r;
  assign den_zero = (den_r == '0);
  assign service  = (last_r <= floor_r);
  assign q_sat    = |div_q_r[MP_W-1:ptlm_pkg::SLOPE_W-1];

  // full-width products of the incoming beat
  assign shot_sq = in_shot_index * in_shot_index;
  assign shot_pw = in_shot_index * in_power_sample;

  assign sts.busy     = (mul_cnt_r != '0) || (div_cnt_r != '0);
  assign sts.out_free = !ov_r || out_ready;

  always_comb begin
    case (cmd.sel)
      ptlm_pkg::SEL_N_SQ:   begin
        op_a = DEN_W'(sq_r);  op_b = MB_W'(count_r);
      end
      ptlm_pkg::SEL_SS_SS:  begin
        op_a = DEN_W'(ss_r);  op_b = ss_r;
      end
      ptlm_pkg::SEL_N_SP:   begin
        op_a = DEN_W'(ssp_r); op_b = MB_W'(count_r);
      end
      ptlm_pkg::SEL_SS_SPW: begin
        op_a = DEN_W'(ss_r);  op_b = MB_W'(sp_r);
      end
      ptlm_pkg::SEL_DIFF:   begin
        op_a = den_r;         op_b = MB_W'(diff);
      end
      default: begin
        op_a = '0;            op_b = '0;
      end
    endcase
  end

  assign rem_sh = {div_rem_r[REM_W-2:0], div_q_r[MP_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_d_r});

  // configuration and result handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid) floor_r <= cfg_data;
      if (cmd.op == ptlm_pkg::OP_PUBLISH) ov_r <= 1'b1;
      else if (out_ready)                 ov_r <= 1'b0;
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ss_r    <= '0;
      sp_r    <= '0;
      sq_r    <= '0;
      ssp_r   <= '0;
      last_r  <= '0;
      rej_r   <= 1'b0;
    end else if (cmd.op == ptlm_pkg::OP_LOAD) begin
      if (count_r >= ptlm_pkg::MAX_SAMPLES) begin
        rej_r <= 1'b1;
      end else begin
        rej_r   <= 1'b0;
        count_r <= count_r + 1'b1;
        ss_r    <= ss_r + ptlm_pkg::SS_W'(in_shot_index);
        sp_r    <= sp_r + ptlm_pkg::SP_W'(in_power_sample);
        sq_r    <= sq_r + ptlm_pkg::SQ_W'(shot_sq);
        ssp_r   <= ssp_r + ptlm_pkg::SSP_W'(shot_pw);
        last_r  <= in_power_sample;
      end
    end
  end

  // multiplier and divider sequencing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.op == ptlm_pkg::OP_MUL_START) mul_cnt_r <= ptlm_pkg::MCNT_W'(MB_W);
      else if (mul_cnt_r != '0)             mul_cnt_r <= mul_cnt_r - 1'b1;
      if (cmd.op == ptlm_pkg::OP_DIV_START) div_cnt_r <= ptlm_pkg::DCNT_W'(MP_W);
      else if (div_cnt_r != '0)             div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // payload: one multiplier bit and one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.op == ptlm_pkg::OP_MUL_START) begin
      mul_a_r <= op_a;
      mul_b_r <= op_b;
      mul_p_r <= '0;
    end else if (mul_cnt_r != '0) begin
      mul_p_r <= {mul_p_r[MP_W-2:0], 1'b0}
               + (mul_b_r[MB_W-1] ? MP_W'(mul_a_r) : '0);
      mul_b_r <= {mul_b_r[MB_W-2:0], 1'b0};
    end

    if (cmd.op == ptlm_pkg::OP_DIV_START) begin
      div_rem_r <= '0;
      if (cmd.sel == ptlm_pkg::SEL_SLOPE) begin
        div_q_r <= {(MP_W-NUM_W-ptlm_pkg::FRAC_W)'(0), num_mag_r,
                    ptlm_pkg::FRAC_W'(0)};
        div_d_r <= den_r;
      end else begin
        div_q_r <= prod_r;
        div_d_r <= DEN_W'(num_mag_r);
      end
    end else if (div_cnt_r != '0) begin
      div_rem_r <= rem_ge ? (rem_sh - {1'b0, div_d_r}) : rem_sh;
      div_q_r   <= {div_q_r[MP_W-2:0], rem_ge};
    end

    if (cmd.op == ptlm_pkg::OP_MUL_SAVE) begin
      case (cmd.sel)
        ptlm_pkg::SEL_N_SQ, ptlm_pkg::SEL_N_SP: t_r <= mul_p_r[DEN_W-1:0];
        ptlm_pkg::SEL_SS_SS:
          den_r <= (t_r >= mul_p_r[DEN_W-1:0]) ? (t_r - mul_p_r[DEN_W-1:0]) : '0;
        ptlm_pkg::SEL_SS_SPW: begin
          num_neg_r <= (t_r < mul_p_r[DEN_W-1:0]);
          num_mag_r <= (t_r < mul_p_r[DEN_W-1:0]) ?
                       NUM_W'(mul_p_r[DEN_W-1:0] - t_r) :
                       NUM_W'(t_r - mul_p_r[DEN_W-1:0]);
        end
        ptlm_pkg::SEL_DIFF: prod_r <= mul_p_r;
        default: ;
      endcase
    end

    if (cmd.op == ptlm_pkg::OP_DIV_SAVE) begin
      if (cmd.sel == ptlm_pkg::SEL_SLOPE) begin
        if (den_zero)       slope_r <= '0;
        else if (num_neg_r) slope_r <= q_sat ? 32'h8000_0000 : (32'd0 - div_q_r[31:0]);
        else                slope_r <= q_sat ? 32'h7FFF_FFFF : div_q_r[31:0];
      end else begin
        svc_r <= service;
        if (service)
          rul_r <= '0;
        else if (num_neg_r && !den_zero)
          rul_r <= (div_q_r > MP_W'(ptlm_pkg::RUL_UNLIMITED)) ?
                   ptlm_pkg::RUL_UNLIMITED : div_q_r[ptlm_pkg::RUL_W-1:0];
        else
          rul_r <= ptlm_pkg::RUL_UNLIMITED;
      end
    end

    if (cmd.op == ptlm_pkg::OP_PUBLISH) begin
      o_cnt_r   <= count_r;
      o_last_r  <= last_r;
      o_slope_r <= slope_r;
      o_svc_r   <= svc_r;
      o_rul_r   <= rul_r;
      o_rej_r   <= rej_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_sample_total    = o_cnt_r;
  assign out_latest_power    = o_last_r;
  assign out_trend_slope     = o_slope_r;
  assign out_service_due     = o_svc_r;
  assign out_shots_remaining = o_rul_r;
  assign out_sample_rejected = o_rej_r;
endmodule

[sv/power_trend_life_monitor_core.sv]
// Optical power trend and remaining-life monitor, top level.
// Joins the ptlm_ctrl sequencer and the ptlm_dp datapath; uses ptlm_pkg.
//
// Input channel (in_valid/in_ready): one beat carries a shot index and a
// power sample. Result channel (out_valid/out_ready): one health beat per
// input beat with count, latest power, Q16.16 slope, service flag, shots
// remaining and a rejected flag. Config channel (cfg_valid/cfg_ready) writes
// the power floor; it is always ready and is meant to be written while idle.
//
// Each sample runs, from accept to out_valid, through five products, each a
// start, 36 shift-add steps and a save; two restoring divisions of 89
// steps with the same start and save; and one publish. One sample is in
// flight at a time; in_ready is high only while the sequencer is idle, so
// a new sample is taken only once the last one is published. The finished
// result sits in an output register, so the next sample is accepted while a
// result waits; a stalled receiver holds the result and, once the next one
// is computed, the sequencer waits for it.
// Synchronous reset clears the sums, the count, the floor and out_valid.
module power_trend_life_monitor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ptlm_pkg::SHOT_W-1:0]  in_shot_index,
  input  logic [ptlm_pkg::POW_W-1:0]   in_power_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ptlm_pkg::CNT_W-1:0]   out_sample_total,
  output logic [ptlm_pkg::POW_W-1:0]   out_latest_power,
  output logic signed [ptlm_pkg::SLOPE_W-1:0] out_trend_slope,
  output logic                         out_service_due,
  output logic [ptlm_pkg::RUL_W-1:0]   out_shots_remaining,
  output logic                         out_sample_rejected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [15:0]                  cfg_data
);
  ptlm_pkg::cmd_t    cmd;
  ptlm_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  ptlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptlm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_shot_index       (in_shot_index),
    .in_power_sample     (in_power_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sample_total    (out_sample_total),
    .out_latest_power    (out_latest_power),
    .out_trend_slope     (out_trend_slope),
    .out_service_due     (out_service_due),
    .out_shots_remaining (out_shots_remaining),
    .out_sample_rejected (out_sample_rejected)
  );
endmodule
